// ----- rtl/bdtr_pkg.sv -----
// Package for the big-digit timer renderer: widths, register indexes,
// decimal weights and the big-digit glyph table. No dependencies.
package bdtr_pkg;

  localparam int unsigned MsW      = 17;
  localparam int unsigned ColW     = 7;
  localparam int unsigned RowW     = 2;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned RegW     = 5;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned DigitW   = 4;

  localparam logic [CfgIdxW-1:0] RegColumnOffset = 8'd0;
  localparam logic [CfgIdxW-1:0] RegTensColumn   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegOnesColumn   = 8'd2;
  localparam logic [CfgIdxW-1:0] RegTenthsColumn = 8'd3;

  localparam logic [RegW-1:0] ColumnOffsetRst = 5'd0;
  localparam logic [RegW-1:0] TensColumnRst   = 5'd0;
  localparam logic [RegW-1:0] OnesColumnRst   = 5'd4;
  localparam logic [RegW-1:0] TenthsColumnRst = 5'd9;

  localparam logic [MsW-1:0]    MsMax     = 17'd99999;
  localparam logic [DigitW-1:0] BlankMark = 4'd15;
  localparam logic [CodeW-1:0]  SpaceCode = 8'h20;

  typedef logic [DigitW-1:0] digit_t;

  // Decimal weights in ms for tens of seconds, seconds, tenths.
  function automatic logic [MsW-1:0] weight(input logic [1:0] k);
    case (k)
      2'd0:    weight = 17'd10000;
      2'd1:    weight = 17'd1000;
      default: weight = 17'd100;
    endcase
  endfunction

  localparam logic [CodeW-1:0] GLYPH [4][30] = '{
    '{8'h01,8'h02,8'h03, 8'hFE,8'h01,8'h02, 8'h01,8'h02,8'h03, 8'h01,8'h02,8'h03,
      8'h02,8'hFE,8'h02, 8'h02,8'h02,8'h02, 8'h01,8'h02,8'h03, 8'h02,8'h02,8'h02,
      8'h01,8'h02,8'h03, 8'h01,8'h02,8'h03},
    '{8'hFF,8'hFE,8'hFF, 8'hFE,8'hFE,8'hFF, 8'h01,8'h02,8'hFF, 8'hFE,8'h02,8'hFF,
      8'hFF,8'h02,8'hFF, 8'hFF,8'h02,8'h02, 8'hFF,8'h02,8'h03, 8'hFE,8'h01,8'h07,
      8'hFF,8'h02,8'hFF, 8'hFF,8'hFE,8'hFF},
    '{8'hFF,8'hFE,8'hFF, 8'hFE,8'hFE,8'hFF, 8'hFF,8'hFE,8'hFE, 8'hFE,8'hFE,8'hFF,
      8'hFE,8'hFE,8'hFF, 8'hFE,8'hFE,8'hFF, 8'hFF,8'hFE,8'hFF, 8'hFE,8'hFF,8'hFE,
      8'hFF,8'hFE,8'hFF, 8'h04,8'h06,8'hFF},
    '{8'h04,8'h06,8'h05, 8'hFE,8'hFE,8'h06, 8'h06,8'h06,8'h06, 8'h04,8'h06,8'h05,
      8'hFE,8'hFE,8'h06, 8'h04,8'h06,8'h05, 8'h04,8'h06,8'h05, 8'hFE,8'h06,8'hFE,
      8'h04,8'h06,8'h05, 8'hFE,8'hFE,8'h06}
  };

  function automatic logic [CodeW-1:0] glyph_code(input digit_t d, input logic [1:0] r,
                                                  input logic [1:0] c);
    logic [4:0] idx;
    idx = {d[3:0], 1'b0} + {1'b0, d} + {3'b000, c};
    if (d > 4'd9) begin
      glyph_code = SpaceCode;
    end else begin
      glyph_code = GLYPH[r][idx];
    end
  endfunction

endpackage

// ----- rtl/bdtr_in_if.sv -----
// Input channel of the big-digit timer renderer: one timer value a word.
// Depends on bdtr_pkg.
interface bdtr_in_if;
  logic                       valid;
  logic                       ready;
  logic [bdtr_pkg::MsW-1:0]   delay_ms;
  modport source (output valid, output delay_ms, input ready);
  modport sink   (input valid, input delay_ms, output ready);
endinterface

// ----- rtl/bdtr_out_if.sv -----
// Output channel of the big-digit timer renderer: one character write a word.
// Depends on bdtr_pkg.
interface bdtr_out_if;
  logic                        valid;
  logic                        ready;
  logic [bdtr_pkg::ColW-1:0]   column;
  logic [bdtr_pkg::RowW-1:0]   row;
  logic [bdtr_pkg::CodeW-1:0]  char_code;
  logic                        last;
  modport source (output valid, output column, output row, output char_code,
                  output last, input ready);
  modport sink   (input valid, input column, input row, input char_code,
                  input last, output ready);
endinterface

// ----- rtl/bdtr_cfg_if.sv -----
// Configuration write channel of the big-digit timer renderer.
// Depends on bdtr_pkg.
interface bdtr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bdtr_pkg::CfgIdxW-1:0]   index;
  logic [bdtr_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/big_digit_timer_renderer_top.sv -----
// Big-digit timer renderer: ms timer value to big-digit character writes.
// Sequence: the word is loaded, then its digits are extracted by repeated subtract on
// the shared subtractor on 17-bit operands, then one write a cycle while the output
// is not stalled (12 per changed digit); unchanged digits are skipped. A new word is
// taken only in idle, once all writes for the last word have been issued.
// Reset: async active low; column registers to defaults, all digits shown as blank.
// Depends on bdtr_pkg, bdtr_in_if, bdtr_out_if, bdtr_cfg_if.
module big_digit_timer_renderer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  bdtr_in_if.sink     in_i,
  bdtr_cfg_if.sink    cfg_i,
  bdtr_out_if.source  out_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [bdtr_pkg::MsW-1:0] rem_q, rem_d;
  logic [1:0] k_q, k_d;
  bdtr_pkg::digit_t cnt_q, cnt_d;
  bdtr_pkg::digit_t want_q [3];
  bdtr_pkg::digit_t want_d [3];
  bdtr_pkg::digit_t shown_q [3];
  bdtr_pkg::digit_t shown_d [3];
  logic [2:0] diff_q, diff_d;
  logic [1:0] pos_q, pos_d;
  logic [1:0] row_q, row_d;
  logic [1:0] col_q, col_d;

  logic [bdtr_pkg::RegW-1:0] col_off_q, tens_col_q, ones_col_q, tenths_col_q;

  logic                          out_valid_q, out_valid_d;
  logic [bdtr_pkg::ColW-1:0]     out_col_q, out_col_d;
  logic [bdtr_pkg::RowW-1:0]     out_row_q, out_row_d;
  logic [bdtr_pkg::CodeW-1:0]    out_code_q, out_code_d;
  logic                          out_last_q, out_last_d;

  logic [bdtr_pkg::MsW:0]    sub;
  logic [bdtr_pkg::RegW-1:0] pos_col;
  logic                      can_load;
  logic [2:0]                diff_left;
  bdtr_pkg::digit_t          b0, b1, b2;

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid     = out_valid_q;
  assign out_o.column    = out_col_q;
  assign out_o.row       = out_row_q;
  assign out_o.char_code = out_code_q;
  assign out_o.last      = out_last_q;

  assign sub      = {1'b0, rem_q} - {1'b0, bdtr_pkg::weight(k_q)};
  assign can_load = !out_valid_q || out_o.ready;

  always_comb begin
    case (pos_q)
      2'd0:    pos_col = tens_col_q;
      2'd1:    pos_col = ones_col_q;
      default: pos_col = tenths_col_q;
    endcase
  end

  always_comb begin
    b0 = want_q[0];
    b1 = want_q[1];
    b2 = cnt_q;
    if (want_q[0] == 4'd0) begin
      b0 = bdtr_pkg::BlankMark;
      if (want_q[1] == 4'd0) begin
        b1 = bdtr_pkg::BlankMark;
      end
    end
  end

  always_comb begin
    diff_left = diff_q;
    diff_left[pos_q] = 1'b0;
  end

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    want_d      = want_q;
    shown_d     = shown_q;
    diff_d      = diff_q;
    pos_d       = pos_q;
    row_d       = row_q;
    col_d       = col_q;
    out_valid_d = out_valid_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    out_code_d  = out_code_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          rem_d   = (in_i.delay_ms > bdtr_pkg::MsMax) ? bdtr_pkg::MsMax : in_i.delay_ms;
          k_d     = 2'd0;
          cnt_d   = 4'd0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (!sub[bdtr_pkg::MsW]) begin
          rem_d = sub[bdtr_pkg::MsW-1:0];
          cnt_d = cnt_q + 4'd1;
        end else if (k_q == 2'd2) begin
          want_d[0] = b0;
          want_d[1] = b1;
          want_d[2] = b2;
          diff_d    = {b2 != shown_q[2], b1 != shown_q[1], b0 != shown_q[0]};
          pos_d     = 2'd0;
          row_d     = 2'd0;
          col_d     = 2'd0;
          state_d   = S_EMIT;
        end else begin
          want_d[k_q] = cnt_q;
          k_d         = k_q + 2'd1;
          cnt_d       = 4'd0;
        end
      end
      S_EMIT: begin
        if (diff_q == 3'b000) begin
          state_d = S_IDLE;
        end else if (!diff_q[pos_q]) begin
          pos_d = pos_q + 2'd1;
        end else if (can_load) begin
          out_valid_d = 1'b1;
          out_col_d   = 7'(col_off_q) + 7'(pos_col) + 7'(col_q);
          out_row_d   = row_q;
          out_code_d  = bdtr_pkg::glyph_code(want_q[pos_q], row_q, col_q);
          out_last_d  = (row_q == 2'd3) && (col_q == 2'd2) && (diff_left == 3'b000);
          if (col_q == 2'd2) begin
            col_d = 2'd0;
            if (row_q == 2'd3) begin
              row_d          = 2'd0;
              diff_d         = diff_left;
              shown_d[pos_q] = want_q[pos_q];
              pos_d          = pos_q + 2'd1;
            end else begin
              row_d = row_q + 2'd1;
            end
          end else begin
            col_d = col_q + 2'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      shown_q      <= '{bdtr_pkg::BlankMark, bdtr_pkg::BlankMark, bdtr_pkg::BlankMark};
      col_off_q    <= bdtr_pkg::ColumnOffsetRst;
      tens_col_q   <= bdtr_pkg::TensColumnRst;
      ones_col_q   <= bdtr_pkg::OnesColumnRst;
      tenths_col_q <= bdtr_pkg::TenthsColumnRst;
      diff_q       <= 3'b000;
      pos_q        <= 2'd0;
      row_q        <= 2'd0;
      col_q        <= 2'd0;
      k_q          <= 2'd0;
      cnt_q        <= 4'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      shown_q     <= shown_d;
      diff_q      <= diff_d;
      pos_q       <= pos_d;
      row_q       <= row_d;
      col_q       <= col_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          bdtr_pkg::RegColumnOffset: col_off_q    <= cfg_i.data[bdtr_pkg::RegW-1:0];
          bdtr_pkg::RegTensColumn:   tens_col_q   <= cfg_i.data[bdtr_pkg::RegW-1:0];
          bdtr_pkg::RegOnesColumn:   ones_col_q   <= cfg_i.data[bdtr_pkg::RegW-1:0];
          bdtr_pkg::RegTenthsColumn: tenths_col_q <= cfg_i.data[bdtr_pkg::RegW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    want_q     <= want_d;
    out_col_q  <= out_col_d;
    out_row_q  <= out_row_d;
    out_code_q <= out_code_d;
    out_last_q <= out_last_d;
  end

endmodule
